// ===== sv/lpht_pkg.sv =====
// Shared constants, payload types and control structs for the linear probe hash table.
package lpht_pkg;

    localparam int SLOTS      = 128;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = $clog2(SLOTS);

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [VALUE_BITS-1:0] result_value;
    } resp_t;

    typedef struct packed {
        logic load;
        logic read;
        logic advance;
        logic decide;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic match;
        logic last;
        logic out_free;
    } sts_t;

endpackage

// ===== sv/linear_probe_hash_table.sv =====
// Top level of the open-addressing key/value table with linear probing.
//
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    lpht_pkg::req_t  (req_type, key, value)
// resp      out        resp_valid/resp_ready  lpht_pkg::resp_t (status, result_value)
//
// A request runs through p probes, a decision and a commit, where p (1 to SLOTS) is the
// number of slots probed; each probe is one registered read of the slot stores.
// One request is in work at a time; the next transfer is taken once the result is loaded.
// A result waiting in the output register holds the commit of the following request only.
// Reset clears all valid bits at once, so the table is empty with no clearing pass.
module linear_probe_hash_table (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  lpht_pkg::req_t  req,
    output logic            resp_valid,
    input  logic            resp_ready,
    output lpht_pkg::resp_t resp
);

    lpht_pkg::cmd_t cmd;
    lpht_pkg::sts_t sts;

    lpht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lpht_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

// ===== sv/lpht_ctrl.sv =====
// Controller state machine that sequences the probe, decision and commit steps.
module lpht_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  lpht_pkg::sts_t sts,
    output lpht_pkg::cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.empty || sts.match || sts.last)
                begin
                    cmd.decide = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/lpht_dpath.sv =====
// Datapath with the slot stores, probe position, result decision and output register.
module lpht_dpath (
    input  logic           clk,
    input  logic           rst_n,
    input  lpht_pkg::req_t req,
    output logic           resp_valid,
    input  logic           resp_ready,
    output lpht_pkg::resp_t resp,
    input  lpht_pkg::cmd_t cmd,
    output lpht_pkg::sts_t sts
);

    logic [lpht_pkg::KEY_BITS-1:0]   key_mem [lpht_pkg::SLOTS];
    logic [lpht_pkg::VALUE_BITS-1:0] val_mem [lpht_pkg::SLOTS];
    logic [lpht_pkg::SLOTS-1:0]      valid_reg;

    lpht_pkg::req_t                  req_reg;
    logic [lpht_pkg::IDX_BITS-1:0]   pos_reg;
    logic [lpht_pkg::IDX_BITS-1:0]   cnt_reg;
    logic [lpht_pkg::KEY_BITS-1:0]   key_rd_reg;
    logic [lpht_pkg::VALUE_BITS-1:0] val_rd_reg;
    logic                            valid_rd_reg;

    logic [1:0]                      res_status_reg;
    logic [lpht_pkg::VALUE_BITS-1:0] res_value_reg;
    logic                            wr_reg;
    logic                            clr_reg;

    logic                            out_valid_reg;
    lpht_pkg::resp_t                 out_reg;

    logic [1:0]                      res_status_next;
    logic [lpht_pkg::VALUE_BITS-1:0] res_value_next;
    logic                            wr_next;
    logic                            clr_next;
    logic [lpht_pkg::IDX_BITS-1:0]   pos_next;

    assign sts.empty    = !valid_rd_reg;
    assign sts.match    = valid_rd_reg && (key_rd_reg == req_reg.key);
    assign sts.last     = (cnt_reg == lpht_pkg::IDX_BITS'(lpht_pkg::SLOTS - 1));
    assign sts.out_free = !out_valid_reg || resp_ready;

    assign resp_valid = out_valid_reg;
    assign resp       = out_reg;

    always_comb
    begin
        if (pos_reg == lpht_pkg::IDX_BITS'(lpht_pkg::SLOTS - 1))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_comb
    begin
        res_status_next = lpht_pkg::ST_NOT_FOUND;
        res_value_next  = '0;
        wr_next         = 1'b0;
        clr_next        = 1'b0;
        case (req_reg.req_type)
            lpht_pkg::REQ_INSERT:
            begin
                if (sts.match || sts.empty)
                begin
                    res_status_next = lpht_pkg::ST_OK;
                    wr_next         = 1'b1;
                end
                else
                begin
                    res_status_next = lpht_pkg::ST_FULL;
                end
            end
            lpht_pkg::REQ_REMOVE:
            begin
                if (sts.match)
                begin
                    res_status_next = lpht_pkg::ST_OK;
                    res_value_next  = val_rd_reg;
                    clr_next        = 1'b1;
                end
            end
            default:
            begin
                if (sts.match)
                begin
                    res_status_next = lpht_pkg::ST_OK;
                    res_value_next  = val_rd_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
            pos_reg <= lpht_pkg::IDX_BITS'(req.key % lpht_pkg::SLOTS);
            cnt_reg <= '0;
        end
        else if (cmd.advance)
        begin
            pos_reg <= pos_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.read)
        begin
            key_rd_reg   <= key_mem[pos_reg];
            val_rd_reg   <= val_mem[pos_reg];
            valid_rd_reg <= valid_reg[pos_reg];
        end
        if (cmd.decide)
        begin
            res_status_reg <= res_status_next;
            res_value_reg  <= res_value_next;
            wr_reg         <= wr_next;
            clr_reg        <= clr_next;
        end
        if (cmd.commit && wr_reg)
        begin
            key_mem[pos_reg] <= req_reg.key;
            val_mem[pos_reg] <= req_reg.value;
        end
        if (cmd.commit)
        begin
            out_reg.status       <= res_status_reg;
            out_reg.result_value <= res_value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit && wr_reg)
            begin
                valid_reg[pos_reg] <= 1'b1;
            end
            else if (cmd.commit && clr_reg)
            begin
                valid_reg[pos_reg] <= 1'b0;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (resp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // A result is loaded only when the output register is empty or draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || resp_ready))
        else $error("result loaded over an untaken transfer");

    // A committed insert leaves its slot occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && wr_reg) |=> valid_reg[$past(pos_reg)])
        else $error("inserted slot not marked valid");

    // A committed remove leaves its slot empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && clr_reg && !wr_reg) |=> !valid_reg[$past(pos_reg)])
        else $error("removed slot still marked valid");

    // A probe that finds neither the key nor a free slot has covered every slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.decide && !sts.empty && !sts.match) |-> sts.last)
        else $error("probe ended before a full pass");
`endif

endmodule
